@@ src/emfd_pkg.sv @@
// Package for the multi-turn encoder feedback decoder.
// Holds field widths, register codes and the stage payload type; no dependencies.
`timescale 1ns / 1ps

package emfd_pkg;

    localparam int PAYLOAD_W  = 64;
    localparam int TICK_W     = 13;
    localparam int TURN_W     = 16;
    localparam int RATIO_W    = 21;
    localparam int TOTAL_W    = 33;
    localparam int SPEED_W    = 21;
    localparam int CUR_W      = 16;
    localparam int TEMP_W     = 8;
    localparam int FRAC_W     = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 21;

    // Multi-turn angle is the turn count with the tick angle appended below it.
    localparam int MULTI_W      = TURN_W + TICK_W;
    localparam int TOTAL_PROD_W = MULTI_W + RATIO_W + 1;
    localparam int SPEED_PROD_W = CUR_W + RATIO_W + 1;

    localparam logic signed [TICK_W:0] HALF_TURN    = (TICK_W + 1)'(4096);
    localparam logic [RATIO_W-1:0]     RATIO_RESET  = RATIO_W'(65536);
    localparam logic signed [TURN_W-1:0] TURN_MAX   = {1'b0, {(TURN_W-1){1'b1}}};
    localparam logic signed [TURN_W-1:0] TURN_MIN   = {1'b1, {(TURN_W-1){1'b0}}};

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ENCODER_OFFSET = 1'b0;
    localparam t_cfg_idx CFG_RATIO_Q16      = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0]         angle;
        logic signed [TURN_W-1:0]  turns;
        logic signed [MULTI_W-1:0] multi;
        logic signed [CUR_W-1:0]   speed;
        logic signed [CUR_W-1:0]   current;
        logic [TEMP_W-1:0]         temp;
    } t_unwrap;

endpackage

@@ src/emfd_in_if.sv @@
// Input channel of the decoder: one 64-bit feedback frame per transaction.
// Depends on emfd_pkg.
`timescale 1ns / 1ps

interface emfd_in_if import emfd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PAYLOAD_W-1:0] frame_payload;

    modport source (output valid, output frame_payload, input ready);
    modport sink   (input valid, input frame_payload, output ready);
endinterface

@@ src/emfd_out_if.sv @@
// Output channel of the decoder: one decoded result per transaction.
// Depends on emfd_pkg.
`timescale 1ns / 1ps

interface emfd_out_if import emfd_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [TICK_W-1:0]           angle_ticks;
    logic signed [TURN_W-1:0]    turn_count;
    logic signed [TOTAL_W-1:0]   total_angle;
    logic signed [SPEED_W-1:0]   speed_scaled;
    logic signed [CUR_W-1:0]     current_raw;
    logic [TEMP_W-1:0]           temperature;

    modport source (output valid, output angle_ticks, output turn_count, output total_angle,
                    output speed_scaled, output current_raw, output temperature,
                    input ready);
    modport sink   (input valid, input angle_ticks, input turn_count, input total_angle,
                    input speed_scaled, input current_raw, input temperature,
                    output ready);
endinterface

@@ src/encoder_multiturn_feedback_decoder.sv @@
// Multi-turn encoder feedback decoder takes one 8-byte motor feedback frame per transaction and
// returns one result per frame: the offset-corrected angle in ticks, a saturating turn count,
// the multi-turn angle and the speed scaled by the Q16 gear ratio, the raw current and the
// temperature. It accepts a frame every cycle while results are taken; each frame passes the
// input register, the turn stage, the multiplier stage and the output register before its
// result is valid. The frame rate is set by the turn counter stage, whose compare and
// saturating update complete within that stage, ahead of the multiplier stage. Every stage
// holds under back-pressure and fills its bubbles, so input stays ready while a result waits
// until all four stages hold a frame.
// Configuration writes take effect at once and are meant to be made while the block is idle.
// Depends on emfd_pkg, emfd_in_if, emfd_out_if, emfd_unwrap and emfd_scale.
`timescale 1ns / 1ps

module encoder_multiturn_feedback_decoder import emfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    emfd_in_if.sink               i_in,
    emfd_out_if.source            o_out
);

    logic [TICK_W-1:0]  r_offset;
    logic [RATIO_W-1:0] r_ratio;

    logic    mid_valid;
    logic    mid_ready;
    t_unwrap mid_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_ratio  <= RATIO_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENCODER_OFFSET: r_offset <= i_cfg_data[TICK_W-1:0];
                CFG_RATIO_Q16:      r_ratio  <= i_cfg_data[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    emfd_unwrap u_unwrap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_offset (r_offset),
        .o_valid  (mid_valid),
        .i_ready  (mid_ready),
        .o_data   (mid_data)
    );

    emfd_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_data  (mid_data),
        .i_ratio (r_ratio),
        .o_out   (o_out)
    );

endmodule

@@ src/emfd_unwrap.sv @@
// Frame input register, field unpack and turn tracking stage.
// Depends on emfd_pkg and emfd_in_if.
`timescale 1ns / 1ps

module emfd_unwrap import emfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    emfd_in_if.sink           i_in,
    input  logic [TICK_W-1:0] i_offset,
    output logic              o_valid,
    input  logic              i_ready,
    output t_unwrap           o_data
);

    logic                 r_s1_valid;
    logic [PAYLOAD_W-1:0] r_s1_payload;
    logic                 r_s2_valid;
    t_unwrap              r_s2_data;
    logic [TICK_W-1:0]    r_prev_angle;
    logic signed [TURN_W-1:0] r_turns;

    logic                     adv2;
    logic [TICK_W-1:0]        n_angle;
    logic signed [TICK_W:0]   diff;
    logic signed [TURN_W-1:0] n_turns;
    t_unwrap                  n_data;

    assign adv2       = r_s1_valid && (!r_s2_valid || i_ready);
    assign i_in.ready = !r_s1_valid || adv2;

    always_comb begin
        // Only the low tick bits matter since the angle wraps every turn.
        n_angle = r_s1_payload[48 +: TICK_W] - i_offset;
        diff    = $signed({1'b0, n_angle}) - $signed({1'b0, r_prev_angle});
        n_turns = r_turns;
        if (diff > HALF_TURN) begin
            if (r_turns != TURN_MIN) n_turns = r_turns - TURN_W'(1);
        end else if (diff < -HALF_TURN) begin
            if (r_turns != TURN_MAX) n_turns = r_turns + TURN_W'(1);
        end
        n_data.angle   = n_angle;
        n_data.turns   = n_turns;
        n_data.multi   = {n_turns, n_angle};
        n_data.speed   = r_s1_payload[47:32];
        n_data.current = r_s1_payload[31:16];
        n_data.temp    = r_s1_payload[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_prev_angle <= '0;
            r_turns      <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_s1_valid <= 1'b1;
            end else if (adv2) begin
                r_s1_valid <= 1'b0;
            end
            if (adv2) begin
                r_s2_valid   <= 1'b1;
                r_prev_angle <= n_angle;
                r_turns      <= n_turns;
            end else if (i_ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_payload <= i_in.frame_payload;
        end
        if (adv2) begin
            r_s2_data <= n_data;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_data  = r_s2_data;

endmodule

@@ src/emfd_scale.sv @@
// Gear ratio scaling: multiply stage, then floor shift and saturation into the output register.
// Depends on emfd_pkg and emfd_out_if.
`timescale 1ns / 1ps

module emfd_scale import emfd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_unwrap            i_data,
    input  logic [RATIO_W-1:0] i_ratio,
    emfd_out_if.source         o_out
);

    logic                            r_s3_valid;
    t_unwrap                         r_s3_data;
    logic signed [TOTAL_PROD_W-1:0]  r_total_prod;
    logic signed [SPEED_PROD_W-1:0]  r_speed_prod;
    logic                            r_s4_valid;

    logic                            adv3;
    logic                            adv4;
    logic signed [TOTAL_PROD_W-1:0]  n_total_prod;
    logic signed [SPEED_PROD_W-1:0]  n_speed_prod;
    logic signed [TOTAL_PROD_W-1:0]  total_sh;
    logic signed [SPEED_PROD_W-1:0]  speed_sh;
    logic signed [TOTAL_W-1:0]       n_total;
    logic signed [SPEED_W-1:0]       n_speed;

    assign adv4    = r_s3_valid && (!r_s4_valid || o_out.ready);
    assign o_ready = !r_s3_valid || adv4;
    assign adv3    = i_valid && o_ready;

    always_comb begin
        n_total_prod = $signed(i_data.multi) * $signed({1'b0, i_ratio});
        n_speed_prod = $signed(i_data.speed) * $signed({1'b0, i_ratio});
    end

    always_comb begin
        // Arithmetic shift rounds toward minus infinity.
        total_sh = r_total_prod >>> FRAC_W;
        speed_sh = r_speed_prod >>> FRAC_W;
        if (total_sh[TOTAL_PROD_W-1:TOTAL_W-1] == '0
                || total_sh[TOTAL_PROD_W-1:TOTAL_W-1] == '1) begin
            n_total = total_sh[TOTAL_W-1:0];
        end else begin
            n_total = {total_sh[TOTAL_PROD_W-1], {(TOTAL_W-1){~total_sh[TOTAL_PROD_W-1]}}};
        end
        if (speed_sh[SPEED_PROD_W-1:SPEED_W-1] == '0
                || speed_sh[SPEED_PROD_W-1:SPEED_W-1] == '1) begin
            n_speed = speed_sh[SPEED_W-1:0];
        end else begin
            n_speed = {speed_sh[SPEED_PROD_W-1], {(SPEED_W-1){~speed_sh[SPEED_PROD_W-1]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (adv3) begin
                r_s3_valid <= 1'b1;
            end else if (adv4) begin
                r_s3_valid <= 1'b0;
            end
            if (adv4) begin
                r_s4_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_s4_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_s3_data    <= i_data;
            r_total_prod <= n_total_prod;
            r_speed_prod <= n_speed_prod;
        end
        if (adv4) begin
            o_out.angle_ticks  <= r_s3_data.angle;
            o_out.turn_count   <= r_s3_data.turns;
            o_out.total_angle  <= n_total;
            o_out.speed_scaled <= n_speed;
            o_out.current_raw  <= r_s3_data.current;
            o_out.temperature  <= r_s3_data.temp;
        end
    end

    assign o_out.valid = r_s4_valid;

endmodule

@@ tb/encoder_multiturn_feedback_decoder_test.sv @@
// Self-checking testbench for the multi-turn encoder feedback decoder.
// Needs emfd_pkg, emfd_in_if, emfd_out_if and the decoder RTL; nothing else.
`timescale 1ns / 1ps

module encoder_multiturn_feedback_decoder_test;
    import emfd_pkg::*;

    localparam int     PIPE_LATENCY  = 4;
    localparam int     MAX_GAP       = 13;
    localparam int     STALL_LIMIT   = 1000;
    localparam int     MAX_REPORTS   = 10;
    localparam int     RANDOM_PHASES = 6;
    localparam int     PHASE_FRAMES  = 150;
    localparam int     SWEEP_UP      = 120;
    localparam int     SWEEP_DOWN    = 240;
    localparam longint TURN_SPAN     = longint'(1) <<< TICK_W;

    localparam logic [RATIO_W-1:0] RATIO_NOMINAL_MAX = RATIO_W'(1048576);
    localparam logic [RATIO_W-1:0] RATIO_FULL        = '1;

    typedef struct packed {
        logic [TICK_W-1:0]         angle_ticks;
        logic signed [TURN_W-1:0]  turn_count;
        logic signed [TOTAL_W-1:0] total_angle;
        logic signed [SPEED_W-1:0] speed_scaled;
        logic signed [CUR_W-1:0]   current_raw;
        logic [TEMP_W-1:0]         temperature;
    } feedback_t;

    // Tracks the wrap state and registers alongside the block and holds the
    // decodes still owed by it.
    class unwrap_checker;
        logic [TICK_W-1:0]        enc_offset;
        logic [RATIO_W-1:0]       gear_ratio;
        logic [TICK_W-1:0]        last_angle;
        logic signed [TURN_W-1:0] turn_acc;
        feedback_t                pending_decodes[$];
        int unsigned              mismatches;

        function new();
            enc_offset = '0;
            gear_ratio = RATIO_RESET;
            last_angle = '0;
            turn_acc   = '0;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ENCODER_OFFSET: enc_offset = data[TICK_W-1:0];
                CFG_RATIO_Q16:      gear_ratio = data[RATIO_W-1:0];
                default: ;
            endcase
        endfunction

        function longint fit_signed(longint v, int width);
            longint lim;
            lim = longint'(1) <<< (width - 1);
            if (v < -lim)
                return -lim;
            if (v > lim - 1)
                return lim - 1;
            return v;
        endfunction

        function void note_frame(logic [PAYLOAD_W-1:0] frame);
            feedback_t want;
            int        delta;
            longint    multi;
            longint    scaled;
            longint    spd;
            // The 13-bit subtraction wraps, so tick bits above bit 12 drop out.
            want.angle_ticks = frame[48 +: TICK_W] - enc_offset;
            delta = int'(want.angle_ticks) - int'(last_angle);
            if (delta > int'(HALF_TURN)) begin
                if (turn_acc != TURN_MIN)
                    turn_acc = turn_acc - 16'sd1;
            end else if (delta < -int'(HALF_TURN)) begin
                if (turn_acc != TURN_MAX)
                    turn_acc = turn_acc + 16'sd1;
            end
            last_angle = want.angle_ticks;

            multi  = longint'(turn_acc) * TURN_SPAN + longint'(want.angle_ticks);
            scaled = (multi * longint'(gear_ratio)) >>> FRAC_W;
            spd    = (longint'($signed(frame[32 +: CUR_W])) * longint'(gear_ratio)) >>> FRAC_W;

            want.turn_count   = turn_acc;
            want.total_angle  = TOTAL_W'(fit_signed(scaled, TOTAL_W));
            want.speed_scaled = SPEED_W'(fit_signed(spd, SPEED_W));
            want.current_raw  = frame[16 +: CUR_W];
            want.temperature  = frame[8 +: TEMP_W];
            pending_decodes.push_back(want);
        endfunction

        function void check_decode(feedback_t got);
            feedback_t want;
            if (pending_decodes.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: result with nothing outstanding: angle %0d turns %0d",
                             $realtime, got.angle_ticks, got.turn_count);
                mismatches++;
                return;
            end
            want = pending_decodes.pop_front();
            if (got.angle_ticks !== want.angle_ticks || got.turn_count !== want.turn_count ||
                got.total_angle !== want.total_angle ||
                got.speed_scaled !== want.speed_scaled ||
                got.current_raw !== want.current_raw || got.temperature !== want.temperature)
            begin
                if (mismatches < MAX_REPORTS) begin
                    $display("%0t: mismatch (expected/actual) angle %0d/%0d turns %0d/%0d",
                             $realtime, want.angle_ticks, got.angle_ticks,
                             want.turn_count, got.turn_count);
                    $display("    total %0d/%0d speed %0d/%0d current %0d/%0d temp %0d/%0d",
                             want.total_angle, got.total_angle,
                             want.speed_scaled, got.speed_scaled,
                             want.current_raw, got.current_raw,
                             want.temperature, got.temperature);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    emfd_in_if  frame_ch ();
    emfd_out_if result_ch ();

    unwrap_checker     board = new();
    bit                tx_quiet    = 1'b1;
    bit                rx_quiet    = 1'b1;
    bit                rx_stall_en = 1'b1;
    int unsigned       stall_cycles = 0;
    logic [TICK_W-1:0] tick_walk = '0;

    encoder_multiturn_feedback_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (frame_ch),
        .o_out       (result_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [PAYLOAD_W-1:0] pack_frame(logic [15:0] tick, logic [15:0] speed,
                                                        logic [15:0] current, logic [7:0] temp);
        return {tick, speed, current, temp, 8'($urandom)};
    endfunction

    // Mostly a wandering shaft angle, with half-turn-sized jumps and some raw noise.
    function automatic logic [PAYLOAD_W-1:0] next_frame();
        logic [PAYLOAD_W-1:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: tick_walk = raw[48 +: TICK_W];
            1: tick_walk += 13'd4096;
            2: tick_walk += ($urandom_range(0, 1) != 0) ? 13'd4097 : 13'd4095;
            default: tick_walk += 13'($urandom_range(0, 1200)) - 13'd600;
        endcase
        raw[48 +: TICK_W] = tick_walk;
        return raw;
    endfunction

    // Called at a rising edge; returns at the edge where the frame is taken.
    task automatic send_frame(input logic [PAYLOAD_W-1:0] frame);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        frame_ch.valid         <= 1'b1;
        frame_ch.frame_payload <= frame;
        do @(posedge i_clk); while (!frame_ch.ready);
        board.note_frame(frame);
    endtask

    task automatic hold_frames();
        frame_ch.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending_decodes.size() != 0);
    endtask

    task automatic configure(input logic [TICK_W-1:0] offset, input logic [RATIO_W-1:0] ratio);
        hold_frames();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ENCODER_OFFSET;
        cfg_data  <= CFG_DATA_W'(offset);
        @(posedge i_clk);
        board.write_reg(CFG_ENCODER_OFFSET, CFG_DATA_W'(offset));
        cfg_index <= CFG_RATIO_Q16;
        cfg_data  <= CFG_DATA_W'(ratio);
        @(posedge i_clk);
        board.write_reg(CFG_RATIO_Q16, CFG_DATA_W'(ratio));
        cfg_we <= 1'b0;
    endtask

    task automatic sweep_turns(input int frames, input logic [TICK_W-1:0] step);
        repeat (frames) begin
            tick_walk += step;
            send_frame(pack_frame({3'($urandom), tick_walk}, 16'($urandom), 16'($urandom),
                                  8'($urandom)));
        end
    endtask

    initial begin
        feedback_t got;
        int unsigned taken;
        int          gap;
        taken = 0;
        result_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = (rx_quiet || !rx_stall_en) ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
            got.angle_ticks  = result_ch.angle_ticks;
            got.turn_count   = result_ch.turn_count;
            got.total_angle  = result_ch.total_angle;
            got.speed_scaled = result_ch.speed_scaled;
            got.current_raw  = result_ch.current_raw;
            got.temperature  = result_ch.temperature;
            board.check_decode(got);
            taken++;
            if (taken % 37 == 0)
                rx_quiet = ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (frame_ch.valid && frame_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("** encoder_multiturn_feedback_decoder: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [TICK_W-1:0]  offset;
        logic [RATIO_W-1:0] ratio;
        i_rst_n                <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= CFG_ENCODER_OFFSET;
        cfg_data               <= '0;
        frame_ch.valid         <= 1'b0;
        frame_ch.frame_payload <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: the first frame is compared with angle zero, then exact
        // half turns, one tick past half, tick bits above 8191 and full-scale fields.
        send_frame(pack_frame(16'h1000, 16'h7FFF, 16'h7FFF, 8'hFF));
        send_frame(pack_frame(16'h0000, 16'h8000, 16'h8000, 8'h00));
        send_frame(pack_frame(16'h1001, 16'hFFFF, 16'h0001, 8'h55));
        send_frame(pack_frame(16'hE000, 16'h0001, 16'hFFFF, 8'hAA));
        send_frame(pack_frame(16'hFFFF, 16'h0000, 16'h0000, 8'h7F));
        send_frame(pack_frame(16'h0000, 16'h1234, 16'h8000, 8'h80));

        configure(13'h1FFF, RATIO_NOMINAL_MAX);
        send_frame(pack_frame(16'h0000, 16'h7FFF, 16'h7FFF, 8'h01));
        send_frame(pack_frame(16'h1FFE, 16'h8000, 16'h8000, 8'hFE));
        send_frame(pack_frame(16'h3FFF, 16'hFFFF, 16'h0000, 8'h10));

        configure('0, '0);
        send_frame(pack_frame(16'h1000, 16'h8000, 16'h7FFF, 8'h20));
        send_frame({$urandom, $urandom});

        // A tiny ratio shows the floor on negative products.
        configure('0, RATIO_W'(1));
        send_frame(pack_frame(16'h0800, 16'hFFFF, 16'h1111, 8'h30));
        send_frame(pack_frame(16'h0801, 16'h0001, 16'h2222, 8'h40));
        send_frame(pack_frame(16'h0802, 16'h8001, 16'h3333, 8'h50));

        // Run the turn counter up by many turns and then down through zero, back to
        // back, and look at the scaled outputs with the full-scale ratio at each end.
        tick_walk   = 13'($urandom);
        rx_stall_en = 1'b0;
        tx_quiet    = 1'b1;
        configure(13'($urandom), RATIO_NOMINAL_MAX);
        sweep_turns(SWEEP_UP, 13'd4095);
        configure(board.enc_offset, RATIO_FULL);
        sweep_turns(4, 13'd1);
        configure(board.enc_offset, RATIO_NOMINAL_MAX);
        sweep_turns(SWEEP_DOWN, 13'd4097);
        configure(board.enc_offset, RATIO_FULL);
        sweep_turns(4, 13'd1);
        rx_stall_en = 1'b1;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin offset = 13'($urandom); ratio = RATIO_RESET;        end
                1: begin offset = 13'h1FFF;      ratio = RATIO_NOMINAL_MAX;  end
                2: begin offset = '0;            ratio = '0;                 end
                3: begin
                    offset = 13'($urandom);
                    ratio  = RATIO_W'($urandom_range(0, 1048576));
                end
                4: begin offset = 13'($urandom); ratio = RATIO_FULL;         end
                default: begin
                    offset = 13'($urandom);
                    ratio  = RATIO_W'($urandom_range(1, 200000));
                end
            endcase
            configure(offset, ratio);
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                if (n % 40 == 0)
                    tx_quiet = ($urandom_range(0, 2) == 0);
                if (ph == 3 && n == PHASE_FRAMES / 2)
                    hold_frames();
                send_frame(next_frame());
            end
        end

        hold_frames();
        repeat (PIPE_LATENCY * 4) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_decodes.size() == 0)
            $display("** encoder_multiturn_feedback_decoder: PASSED **");
        else
            $display("** encoder_multiturn_feedback_decoder: FAILED **");
        $finish;
    end

endmodule
